// File: design/icdf_pkg.sv
// Shared types and constants for the inverse CDF table lookup core.
// Used by the core, its divider and its checker; depends on nothing.
package icdf_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 17;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int STEP_W  = 5;

    // Stream word layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int FRAC_LSB  = VALUE_W;
    localparam int PCT_LSB   = VALUE_W + FRAC_W;
    localparam int S_PAD_W   = S_TDATA_W - VALUE_W - 2 * FRAC_W;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - COUNT_W;

    // Q1.16 fixed points
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 17'h08000;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [FRAC_W-1:0]         frac_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_EVEN   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } stat_t;

endpackage

// File: design/icdf_div.sv
// Bit-serial restoring divider: one (65536 / divisor) quotient and remainder.
// One quotient bit per cycle. Depends on icdf_pkg.
module icdf_div #(
    parameter int CW = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [icdf_pkg::FRAC_W-1:0] quo,
    output logic [CW-1:0]             rem
);
    import icdf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     rem_reg;
    frac_t             quo_reg;

    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        trial = {rem_reg, quo_reg[FRAC_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    // Sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(FRAC_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath; dividend is shifted out of the quotient register
    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= FRAC_ONE;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= ge ? diff[CW-1:0] : trial[CW-1:0];
            quo_reg  <= {quo_reg[FRAC_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: design/inverse_cdf_table_lookup_core.sv
// Inverse CDF table lookup core: sorted (value, fraction) table and sequencer.
// Depends on icdf_pkg and icdf_div.
//
// Usage:
//   Input words arrive on s_*: s_tuser carries the command (clear, insert,
//   lookup, even fractions), s_tdata the value, fraction and percentile.
//   Each input word yields exactly one result word on m_*: m_tdata carries
//   the found value and the entry count, m_tuser the status.
//   s_tready is high only while the sequencer is idle; one word is worked
//   on at a time. Steps from accept to m_tvalid (n = entries held):
//     clear or insert into a full table: straight to the output register
//     insert: a primed read, then entries moved up (at most n), one per cycle
//     lookup: entries scanned (at most n), one table read per cycle
//     even fractions: the divider, then one write per entry
//   The next word can be taken in the cycle in which m_tvalid rises.
//   The table lives in two single-port-write memories; the shift and scan
//   loops are bound by their one read and one write per cycle.
//   A result waits in the output register while m_tready is low; the core
//   then holds the next result in its sequencer and takes no new word.
//   Reset empties the table (count to zero) and drops any pending result.
module inverse_cdf_table_lookup_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] entry_value, [48:32] entry_fraction, [65:49] query_percentile
    input  logic [icdf_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [icdf_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] result_value, [38:32] entry_count
    output logic [icdf_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [icdf_pkg::STAT_W-1:0]    m_tuser
);
    import icdf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_INS_RD  = 7'b0000010,
        ST_INS_CMP = 7'b0000100,
        ST_LK_RUN  = 7'b0001000,
        ST_DIV     = 7'b0010000,
        ST_EV_RUN  = 7'b0100000,
        ST_OUT     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          hi_reg, hi_next;
    value_t        in_val_reg, in_val_next;
    frac_t         in_frac_reg, in_frac_next;
    frac_t         in_pct_reg, in_pct_next;
    frac_t         acc_q_reg, acc_q_next;
    logic [CW-1:0] acc_r_reg, acc_r_next;
    value_t        res_val_reg, res_val_next;
    stat_t         res_stat_reg, res_stat_next;
    logic          m_valid_reg, m_valid_next;
    value_t        m_val_reg, m_val_next;
    stat_t         m_stat_reg, m_stat_next;
    logic [COUNT_W-1:0] m_cnt_reg, m_cnt_next;

    // Table memories and registered read port
    value_t val_mem [TABLE_DEPTH];
    frac_t  frac_mem [TABLE_DEPTH];
    value_t val_rd_reg;
    frac_t  frac_rd_reg;

    logic          val_we, frac_we;
    logic [AW-1:0] wr_addr, rd_addr;
    value_t        wr_val;
    frac_t         wr_frac;

    // Divider
    logic          div_start;
    logic          div_done;
    frac_t         div_quo;
    logic [CW-1:0] div_rem;

    // Input word fields
    cmd_t   cmd_in;
    value_t val_in;
    frac_t  frac_in;
    frac_t  pct_in;

    // Helpers
    logic [CW-1:0] idx_m1, idx_m2, lk_addr;
    logic          lk_hit;
    logic [CW:0]   ev_sum_r;
    logic [FRAC_W:0] ev_sum_q;
    logic          ev_wrap;

    assign cmd_in  = cmd_t'(s_tuser);
    assign val_in  = s_tdata[VALUE_W-1:0];
    assign frac_in = s_tdata[FRAC_LSB +: FRAC_W];
    assign pct_in  = s_tdata[PCT_LSB +: FRAC_W];

    icdf_div #(
        .CW(CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (cnt_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Address and compare helpers
    always_comb begin
        idx_m1  = idx_reg - 1'b1;
        idx_m2  = idx_reg - 2'd2;
        lk_addr = hi_reg ? (cnt_reg - 1'b1 - idx_reg) : idx_reg;
        lk_hit  = hi_reg ? (frac_rd_reg <= in_pct_reg) : (frac_rd_reg >= in_pct_reg);
        ev_sum_r = {1'b0, acc_r_reg} + {1'b0, div_rem};
        ev_sum_q = {1'b0, acc_q_reg} + {1'b0, div_quo};
        ev_wrap  = (ev_sum_r >= {1'b0, cnt_reg});
        if (ev_wrap) begin
            ev_sum_r = ev_sum_r - {1'b0, cnt_reg};
            ev_sum_q = ev_sum_q + 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        hi_next       = hi_reg;
        in_val_next   = in_val_reg;
        in_frac_next  = in_frac_reg;
        in_pct_next   = in_pct_reg;
        acc_q_next    = acc_q_reg;
        acc_r_next    = acc_r_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_val_next    = m_val_reg;
        m_stat_next   = m_stat_reg;
        m_cnt_next    = m_cnt_reg;
        val_we        = 1'b0;
        frac_we       = 1'b0;
        wr_addr       = idx_reg[AW-1:0];
        wr_val        = in_val_reg;
        wr_frac       = in_frac_reg;
        rd_addr       = '0;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_val_next   = val_in;
                    in_frac_next  = frac_in;
                    in_pct_next   = pct_in;
                    res_val_next  = '0;
                    res_stat_next = STAT_OK;
                    unique case (cmd_in)
                        CMD_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_OUT;
                        end
                        CMD_INSERT: begin
                            if (cnt_reg == DEPTH_C) begin
                                res_stat_next = STAT_FULL;
                                state_next    = ST_OUT;
                            end else begin
                                idx_next   = cnt_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        CMD_LOOKUP: begin
                            hi_next     = (pct_in > FRAC_HALF);
                            idx_next    = '0;
                            rd_vld_next = 1'b0;
                            state_next  = ST_LK_RUN;
                        end
                        CMD_EVEN: begin
                            if (cnt_reg == '0) begin
                                state_next = ST_OUT;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            // Prime the read of the top entry
            ST_INS_RD: begin
                rd_addr    = idx_m1[AW-1:0];
                state_next = ST_INS_CMP;
            end
            // Move entries not below the new value up by one, then place it
            ST_INS_CMP: begin
                val_we  = 1'b1;
                frac_we = 1'b1;
                if (idx_reg != '0 && val_rd_reg >= in_val_reg) begin
                    wr_val   = val_rd_reg;
                    wr_frac  = frac_rd_reg;
                    idx_next = idx_m1;
                    rd_addr  = idx_m2[AW-1:0];
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_OUT;
                end
            end
            // One read issued per cycle; data compared the cycle after
            ST_LK_RUN: begin
                if (rd_vld_reg && lk_hit) begin
                    res_val_next = val_rd_reg;
                    state_next   = ST_OUT;
                end else if (idx_reg == cnt_reg) begin
                    res_stat_next = STAT_MISS;
                    state_next    = ST_OUT;
                end else begin
                    rd_addr     = lk_addr[AW-1:0];
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    idx_next   = '0;
                    acc_q_next = '0;
                    acc_r_next = '0;
                    state_next = ST_EV_RUN;
                end
            end
            // Running quotient and remainder of (k+1)*65536/n
            ST_EV_RUN: begin
                if (idx_reg == cnt_reg) begin
                    state_next = ST_OUT;
                end else begin
                    frac_we    = 1'b1;
                    wr_frac    = ev_sum_q[FRAC_W-1:0];
                    acc_q_next = ev_sum_q[FRAC_W-1:0];
                    acc_r_next = ev_sum_r[CW-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_stat_next  = res_stat_reg;
                    m_cnt_next   = COUNT_W'(cnt_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        rd_vld_reg   <= rd_vld_next;
        hi_reg       <= hi_next;
        in_val_reg   <= in_val_next;
        in_frac_reg  <= in_frac_next;
        in_pct_reg   <= in_pct_next;
        acc_q_reg    <= acc_q_next;
        acc_r_reg    <= acc_r_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        m_val_reg    <= m_val_next;
        m_stat_reg   <= m_stat_next;
        m_cnt_reg    <= m_cnt_next;
    end

    // Table memories
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_addr] <= wr_val;
        end
        if (frac_we) begin
            frac_mem[wr_addr] <= wr_frac;
        end
        val_rd_reg  <= val_mem[rd_addr];
        frac_rd_reg <= frac_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_cnt_reg, m_val_reg};
    assign m_tuser  = m_stat_reg;

endmodule

// File: design/icdf_chk.sv
// Port-level checker for the inverse CDF table lookup core, with its bind.
// Depends on icdf_pkg and inverse_cdf_table_lookup_core.
module icdf_chk #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [icdf_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [icdf_pkg::CMD_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [icdf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [icdf_pkg::STAT_W-1:0]    m_tuser
);
    import icdf_pkg::*;

    // A waiting input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input word changed while waiting");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One word at a time: ready drops after every accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // A dropped insert reports a full table
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_FULL |->
            m_tdata[VALUE_W +: COUNT_W] == COUNT_W'(TABLE_DEPTH))
        else $error("full status with table not full");

    // A miss returns zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_MISS |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("lookup miss with nonzero value");

endmodule

bind inverse_cdf_table_lookup_core icdf_chk #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_icdf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/inverse_cdf_table_lookup_core_test.sv
// Self-checking bench for inverse_cdf_table_lookup_core: random and directed
// table commands on the input stream, replies checked against a local table copy.
// Depends on icdf_pkg and the core RTL.
module inverse_cdf_table_lookup_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import icdf_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RANDOM_CMDS = 1250;

    typedef struct packed {
        cmd_t   cmd;
        value_t value;
        frac_t  frac;
        frac_t  pct;
        bit     drain_first;   // hold this word back until every reply is in
    } table_cmd_t;

    typedef struct packed {
        value_t             value;
        stat_t              status;
        logic [COUNT_W-1:0] count;
    } table_reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = CMD_CLEAR;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    table_cmd_t   commands_pending[$];
    table_reply_t replies_due[$];
    int           fail_count = 0;

    // Local copy of the table
    value_t tbl_value[DEPTH];
    frac_t  tbl_frac[DEPTH];
    int     held = 0;

    inverse_cdf_table_lookup_core #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Applies one command to the table copy and returns the reply it causes
    task automatic run_table_command(input table_cmd_t c, output table_reply_t r);
        int pos;
        int i;
        bit hit;
        r.value  = '0;
        r.status = STAT_OK;
        hit      = 1'b0;
        case (c.cmd)
            CMD_CLEAR: begin
                held = 0;
            end
            CMD_INSERT: begin
                if (held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // new pair lands ahead of any equal values
                    pos = 0;
                    while (pos < held && $signed(tbl_value[pos]) < $signed(c.value))
                        pos++;
                    for (i = held; i > pos; i--) begin
                        tbl_value[i] = tbl_value[i-1];
                        tbl_frac[i]  = tbl_frac[i-1];
                    end
                    tbl_value[pos] = c.value;
                    tbl_frac[pos]  = c.frac;
                    held++;
                end
            end
            CMD_LOOKUP: begin
                // upper half scans down for last fraction <= pct, else up for first >=
                if (c.pct > FRAC_HALF) begin
                    for (i = held - 1; i >= 0 && !hit; i--) begin
                        if (tbl_frac[i] <= c.pct) begin
                            r.value = tbl_value[i];
                            hit     = 1'b1;
                        end
                    end
                end else begin
                    for (i = 0; i < held && !hit; i++) begin
                        if (tbl_frac[i] >= c.pct) begin
                            r.value = tbl_value[i];
                            hit     = 1'b1;
                        end
                    end
                end
                if (!hit)
                    r.status = STAT_MISS;
            end
            default: begin
                for (i = 0; i < held; i++)
                    tbl_frac[i] = frac_t'(((i + 1) * int'(FRAC_ONE)) / held);
            end
        endcase
        r.count = held[COUNT_W-1:0];
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(0, 3))
            0: return value_t'($urandom);
            1: return value_t'($signed($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return value_t'($urandom_range(0, 65535) << 8);
        endcase
    endfunction

    // Q1.16 numbers: mostly in range, some above one, some at the corners
    function automatic frac_t rand_frac();
        case ($urandom_range(0, 7))
            0: return frac_t'($urandom);
            1: begin
                case ($urandom_range(0, 7))
                    0: return 17'd0;
                    1: return 17'd1;
                    2: return 17'd32767;
                    3: return FRAC_HALF;
                    4: return 17'd32769;
                    5: return 17'd65535;
                    6: return FRAC_ONE;
                    default: return 17'h1FFFF;
                endcase
            end
            default: return frac_t'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic add_word(input cmd_t cmd, input value_t value, input frac_t frac,
                            input frac_t pct, input bit drain);
        table_cmd_t c;
        c.cmd         = cmd;
        c.value       = value;
        c.frac        = frac;
        c.pct         = pct;
        c.drain_first = drain;
        commands_pending.push_back(c);
    endtask

    task automatic add_random_word(input cmd_t cmd, input bit drain);
        add_word(cmd, rand_value(), rand_frac(), rand_frac(), drain);
    endtask

    // Input driver: presents queued commands, predicts each accepted word
    table_cmd_t   cur_cmd;
    table_reply_t predicted;
    int           tx_gap  = 0;
    int           tx_sent = 0;
    bit           tx_calm = 1'b0;

    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_CLEAR;
            tx_gap   = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                run_table_command(cur_cmd, predicted);
                replies_due.push_back(predicted);
                offer  = 1'b0;
                tx_sent++;
                if (tx_sent % 150 == 0)
                    tx_calm = ~tx_calm;
                tx_gap = pick_gap(tx_calm);
            end
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (commands_pending.size() != 0 &&
                             !(commands_pending[0].drain_first && replies_due.size() != 0)) begin
                    cur_cmd = commands_pending.pop_front();
                    offer   = 1'b1;
                    s_tdata <= {{S_PAD_W{1'b0}}, cur_cmd.pct, cur_cmd.frac, cur_cmd.value};
                    s_tuser <= cur_cmd.cmd;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Reply monitor: checks each result word, paces m_tready
    table_reply_t oldest;
    int           rx_gap       = 0;
    int           rx_seen      = 0;
    bit           rx_calm      = 1'b0;
    bit           long_hold_on = 1'b0;

    always @(posedge aclk) begin
        bit rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected word value=%0d status=%0d count=%0d", $time,
                             $signed(m_tdata[VALUE_W-1:0]), m_tuser,
                             m_tdata[VALUE_W +: COUNT_W]);
                    fail_count++;
                end else begin
                    oldest = replies_due.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== oldest.value) begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 $signed(oldest.value), $signed(m_tdata[VALUE_W-1:0]));
                        fail_count++;
                    end
                    if (m_tuser !== oldest.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 oldest.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[VALUE_W +: COUNT_W] !== oldest.count) begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 oldest.count, m_tdata[VALUE_W +: COUNT_W]);
                        fail_count++;
                    end
                end
                rx_seen++;
                if (rx_seen % 170 == 0)
                    rx_calm = ~rx_calm;
                rx_gap = pick_gap(rx_calm);
                // one long back-pressure stretch while the sender keeps offering
                if (!long_hold_on && rx_seen >= 300) begin
                    long_hold_on = 1'b1;
                    rx_gap       = 500;
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int n;
        int i;
        int added;
        bit drain;

        // directed: empty table, extremes, equal values, both scan directions
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd0, 1'b0);
        add_word(CMD_EVEN, 32'sh0, 17'd0, 17'd0, 1'b0);
        add_word(CMD_INSERT, 32'sh7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0);
        add_word(CMD_INSERT, 32'sh8000_0000, 17'd0, 17'd0, 1'b0);
        add_word(CMD_INSERT, 32'sh0, FRAC_ONE, 17'd0, 1'b0);
        add_word(CMD_INSERT, 32'sh0, FRAC_HALF, 17'd0, 1'b0);
        add_word(CMD_INSERT, 32'sh100, 17'd16384, 17'd0, 1'b0);
        add_word(CMD_LOOKUP, -32'sd1, 17'h1FFFF, 17'd0, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd1, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, FRAC_HALF, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd32769, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, FRAC_ONE, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'h1FFFF, 1'b0);
        add_word(CMD_EVEN, 32'sh0, 17'd0, 17'd0, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd13107, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd65535, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, 17'd0, 1'b0);
        add_word(CMD_CLEAR, -32'sd1, 17'h1FFFF, 17'h1FFFF, 1'b0);
        add_word(CMD_LOOKUP, 32'sh0, 17'd0, FRAC_HALF, 1'b0);
        add_word(CMD_EVEN, 32'sh0, 17'd0, 17'd0, 1'b0);

        // random: mostly well-formed load/lookup sequences, some noise
        added = 0;
        drain = 1'b1;
        while (added < RANDOM_CMDS) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 3) != 0) begin
                    add_random_word(CMD_CLEAR, drain);
                    added++;
                    drain = 1'b0;
                end
                // now and then fill past the top to reach the full status
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 20);
                for (i = 0; i < n; i++) begin
                    add_random_word(CMD_INSERT, drain);
                    drain = 1'b0;
                end
                added += n;
                if ($urandom_range(0, 1) == 0) begin
                    add_random_word(CMD_EVEN, 1'b0);
                    added++;
                end
                n = $urandom_range(1, 15);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        add_random_word(CMD_INSERT, 1'b0);
                    else
                        add_random_word(CMD_LOOKUP, 1'b0);
                end
                added += n;
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    add_random_word(cmd_t'($urandom_range(0, 3)), 1'b0);
                added += n;
            end
            drain = ($urandom_range(0, 7) == 0);
        end

        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (commands_pending.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
